>>> rtl/bea_pkg.sv
// Shared constants for the button edge and auto-repeat block.
// Holds the register map, reset values and field widths; no dependencies.
package bea_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_STALE_WINDOW = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIRST_DELAY  = 3'd1;
  localparam logic [IDX_W-1:0] REG_NEXT_DELAY   = 3'd2;
  localparam logic [IDX_W-1:0] REG_TOGGLE_KEY   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MODIFIER_KEY = 3'd4;

  localparam logic [31:0] STALE_WINDOW_RST = 32'd100000;
  localparam logic [31:0] FIRST_DELAY_RST  = 32'd400000;
  localparam logic [31:0] NEXT_DELAY_RST   = 32'd200000;
  localparam logic [31:0] TOGGLE_KEY_RST   = 32'd16;
  localparam logic [31:0] MODIFIER_KEY_RST = 32'd1;

  localparam logic [2:0] HANDLED_PORT = 3'd0;

endpackage

>>> rtl/button_edge_autorepeat_core.sv
// Top level of the button edge detector with auto-repeat and menu toggle.
// Depends on bea_pkg for the register map and reset values.
// A word waits in the input registers until it can advance to the result
// registers. Throughput: one word per cycle unless a valid result is stalled;
// a sample's state update is compare and add logic between those registers.
// Reset clears the state, the valid flags and the registers to their defaults.
module button_edge_autorepeat_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bea_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 port,
  input  logic [31:0]                buttons,
  input  logic [63:0]                time_stamp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       accepted,
  output logic [31:0]                pressed,
  output logic [31:0]                released,
  output logic [31:0]                newly_down,
  output logic [31:0]                held,
  output logic                       menu_toggled,
  output logic                       menu_visible,
  output logic                       deliver
);

  logic [31:0] stale_window;
  logic [31:0] first_repeat_delay;
  logic [31:0] next_repeat_delay;
  logic [31:0] toggle_key_mask;
  logic [31:0] modifier_key_mask;

  logic [31:0] last_buttons;
  logic [63:0] last_time;
  logic [63:0] repeat_deadline;
  logic        menu_shown;

  logic        in_full;
  logic [2:0]  port_r;
  logic [31:0] buttons_r;
  logic [63:0] time_r;

  logic                       cfg_write;
  logic [bea_pkg::IDX_W-1:0]  cfg_idx;
  logic                       advance;
  logic                       take_in;

  logic [63:0] age;
  logic        stale;
  logic        acc;
  logic        changed;
  logic        repeat_due;
  logic [31:0] up;
  logic [31:0] down;
  logic [31:0] press_raw;
  logic        toggle;
  logic [31:0] press_final;
  logic        menu_next;
  logic [63:0] deadline_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[bea_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_window       <= bea_pkg::STALE_WINDOW_RST;
      first_repeat_delay <= bea_pkg::FIRST_DELAY_RST;
      next_repeat_delay  <= bea_pkg::NEXT_DELAY_RST;
      toggle_key_mask    <= bea_pkg::TOGGLE_KEY_RST;
      modifier_key_mask  <= bea_pkg::MODIFIER_KEY_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        bea_pkg::REG_STALE_WINDOW: stale_window       <= pwdata;
        bea_pkg::REG_FIRST_DELAY:  first_repeat_delay <= pwdata;
        bea_pkg::REG_NEXT_DELAY:   next_repeat_delay  <= pwdata;
        bea_pkg::REG_TOGGLE_KEY:   toggle_key_mask    <= pwdata;
        bea_pkg::REG_MODIFIER_KEY: modifier_key_mask  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bea_pkg::REG_STALE_WINDOW: prdata = stale_window;
      bea_pkg::REG_FIRST_DELAY:  prdata = first_repeat_delay;
      bea_pkg::REG_NEXT_DELAY:   prdata = next_repeat_delay;
      bea_pkg::REG_TOGGLE_KEY:   prdata = toggle_key_mask;
      bea_pkg::REG_MODIFIER_KEY: prdata = modifier_key_mask;
      default:                   prdata = 32'd0;
    endcase
  end

  assign advance  = in_full && !(out_valid && out_stall);
  assign in_stall = in_full && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_in) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      port_r    <= port;
      buttons_r <= buttons;
      time_r    <= time_stamp;
    end
  end

  always_comb begin
    age        = last_time - time_r;
    stale      = age < {32'd0, stale_window};
    acc        = (port_r == bea_pkg::HANDLED_PORT) && !stale;
    changed    = buttons_r != last_buttons;
    repeat_due = !changed && (repeat_deadline < time_r);
    up         = changed ? (last_buttons & ~buttons_r) : 32'd0;
    down       = changed ? (buttons_r & ~last_buttons) : 32'd0;
    press_raw  = changed ? down : (repeat_due ? buttons_r : 32'd0);
    toggle     = ((press_raw & toggle_key_mask) != 32'd0) &&
                 ((buttons_r & modifier_key_mask) != 32'd0);
    press_final = toggle ? (press_raw & ~toggle_key_mask) : press_raw;
    menu_next  = menu_shown ^ toggle;
    if (changed) begin
      deadline_next = time_r + {32'd0, first_repeat_delay};
    end else if (repeat_due) begin
      deadline_next = time_r + {32'd0, next_repeat_delay};
    end else begin
      deadline_next = repeat_deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons    <= 32'd0;
      last_time       <= 64'd0;
      repeat_deadline <= 64'd0;
      menu_shown      <= 1'b0;
    end else if (advance && acc) begin
      last_buttons    <= buttons_r;
      last_time       <= time_r;
      repeat_deadline <= deadline_next;
      menu_shown      <= menu_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      accepted     <= acc;
      pressed      <= acc ? press_final : 32'd0;
      released     <= acc ? up : 32'd0;
      newly_down   <= acc ? down : 32'd0;
      held         <= acc ? buttons_r : 32'd0;
      menu_toggled <= acc && toggle;
      menu_visible <= acc ? menu_next : menu_shown;
      deliver      <= acc && (press_final != 32'd0) && menu_next;
    end
  end

endmodule

>>> rtl/bea_checker.sv
// Port-level checks for button_edge_autorepeat_core, attached by bind.
// Needs no package; it only watches the result port and the ready line.
// The checks cover result consistency, the result handshake and the ready line.
module bea_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pready,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       accepted,
  input logic [31:0]                pressed,
  input logic [31:0]                released,
  input logic [31:0]                newly_down,
  input logic [31:0]                held,
  input logic                       menu_toggled,
  input logic                       menu_visible,
  input logic                       deliver
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressed) && $stable(held))
    else $error("Stalled result word changed.");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> pressed == 32'd0 && released == 32'd0 &&
      newly_down == 32'd0 && held == 32'd0 && !menu_toggled && !deliver)
    else $error("Rejected sample carries events.");

  a_deliver: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> deliver == ((pressed != 32'd0) && menu_visible))
    else $error("Deliver flag disagrees with pressed and menu state.");

  a_edges: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> (released & newly_down) == 32'd0 &&
      (newly_down & ~held) == 32'd0 && (released & held) == 32'd0)
    else $error("Edge masks disagree with the held mask.");

  a_ready: assert property (@(posedge clk) pready)
    else $error("Configuration port not ready.");

endmodule

bind button_edge_autorepeat_core bea_checker u_bea_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .accepted     (accepted),
  .pressed      (pressed),
  .released     (released),
  .newly_down   (newly_down),
  .held         (held),
  .menu_toggled (menu_toggled),
  .menu_visible (menu_visible),
  .deliver      (deliver)
);
